// ----- rtl/core/assembly_line_lexer_assert.svh -----
// Assertion macros shared by the assembly line lexer RTL.
// Clocked on clk and disabled while rst_n is low; no other dependencies.
`ifndef ASSEMBLY_LINE_LEXER_ASSERT_SVH
`define ASSEMBLY_LINE_LEXER_ASSERT_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define ASLEX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The expression must never be true out of reset.
`define ASLEX_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ----- rtl/core/aslex_pkg.sv -----
// Types, constants and the character classifier of the assembly line lexer.
// Used by every module of the block; depends on nothing else.
package aslex_pkg;

  localparam logic [1:0] KIND_DROP    = 2'd0;
  localparam logic [1:0] KIND_CONT    = 2'd1;
  localparam logic [1:0] KIND_START   = 2'd2;
  localparam logic [1:0] KIND_SPECIAL = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  localparam int CountW    = 9;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic              quoting;
    logic              commenting;
    logic              inside_word;
    logic [CountW-1:0] token_count;
  } lex_state_t;

  typedef struct packed {
    logic [1:0] kind;
    lex_state_t st;
  } class_res_t;

  typedef struct packed {
    logic [7:0]        ch;
    logic [1:0]        kind;
    logic [CountW-1:0] count;
  } res_t;

  // One queue entry holds every result caused by one accepted character.
  typedef struct packed {
    logic two;
    logic line_end;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_separator(logic [7:0] c);
    logic sep;
    sep = (c inside {CH_SPACE, [CH_TAB:CH_CR], CH_COMMA, CH_HASH});
    return sep;
  endfunction

  function automatic class_res_t classify(logic [7:0] c, lex_state_t st,
                                          logic [CountW-1:0] cap);
    class_res_t r;
    r.st   = st;
    r.kind = KIND_DROP;
    if (st.commenting) begin
      r.kind = KIND_DROP;
    end else if (c == CH_SEMI) begin
      r.st.commenting  = 1'b1;
      r.st.inside_word = 1'b0;
    end else if (c inside {CH_QUOTE, CH_LBRACK, CH_RBRACK, CH_COLON}) begin
      if (c == CH_QUOTE) begin
        r.st.quoting = !st.quoting;
      end
      r.st.inside_word = 1'b0;
      if (st.token_count < cap) begin
        r.st.token_count = st.token_count + CountW'(1);
      end
      r.kind = KIND_SPECIAL;
    end else if (c == CH_NUL || (!st.quoting && is_separator(c))) begin
      r.st.inside_word = 1'b0;
    end else if (st.inside_word) begin
      r.kind = KIND_CONT;
    end else begin
      r.st.inside_word = 1'b1;
      if (st.token_count < cap) begin
        r.st.token_count = st.token_count + CountW'(1);
      end
      r.kind = KIND_START;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/assembly_line_lexer.sv -----
// Assembly line lexer top level: front end, entry queue and back end.
// A character's results enter the queue on its transfer and are offered from its head.
// Throughput: one character per cycle while the queue is not full; a character that
// releases a held slash yields two results, presented one per output transfer. A held
// slash yields nothing until the next character. The four-entry queue absorbs this.
// Reset: synchronous, active low; clears the line state, the queue and the output.
`include "assembly_line_lexer_assert.svh"

module assembly_line_lexer #(
  parameter int MAX_LINE_CHARS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_ch,
  input  logic                         in_line_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_ch,
  output logic [1:0]                   out_kind,
  output logic [aslex_pkg::CountW-1:0] out_tokens_in_line,
  output logic                         out_line_done,
  output logic                         out_last
);

  localparam int CapInt = (MAX_LINE_CHARS < 511) ? MAX_LINE_CHARS : 511;
  localparam logic [aslex_pkg::CountW-1:0] CountCap = aslex_pkg::CountW'(CapInt);

  logic                 q_push;
  logic                 q_pop;
  aslex_pkg::entry_t    q_wr;
  aslex_pkg::entry_t    q_head;
  aslex_pkg::q_status_t q_status;

  assign in_ready = !q_status.full;

  aslex_front #(
    .COUNT_CAP(CountCap)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch      (in_ch),
    .in_line_end(in_line_end),
    .push       (q_push),
    .entry      (q_wr)
  );

  aslex_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_entry(q_wr),
    .pop     (q_pop),
    .head    (q_head),
    .status  (q_status)
  );

  aslex_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .status            (q_status),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ch            (out_ch),
    .out_kind          (out_kind),
    .out_tokens_in_line(out_tokens_in_line),
    .out_line_done     (out_line_done),
    .out_last          (out_last)
  );

  `ASLEX_ASSERT_NEVER(a_push_when_full, q_push && q_status.full, "push into full queue")
  `ASLEX_ASSERT_IMP(a_pop_on_last, q_pop, out_valid && out_ready && out_last,
                    "entry released before its last result")
  `ASLEX_ASSERT_IMP(a_line_done_last, out_valid && out_line_done, out_last,
                    "line end on a result that is not the last")
  `ASLEX_ASSERT_IMP(a_count_capped, out_valid, out_tokens_in_line <= CountCap,
                    "token count above its cap")

endmodule

// ----- rtl/core/aslex_front.sv -----
// Front end of the lexer: accepts characters, keeps the line state and the held slash,
// and builds one queue entry per accepted character that it does not hold. Depends on aslex_pkg.
module aslex_front #(
  parameter logic [aslex_pkg::CountW-1:0] COUNT_CAP = 9'd256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_ch,
  input  logic              in_line_end,
  output logic              push,
  output aslex_pkg::entry_t entry
);

  aslex_pkg::lex_state_t st_r, st_nxt;
  logic                  slash_held_r, slash_held_nxt;
  aslex_pkg::class_res_t ca, cb;
  logic                  fire;
  logic                  hold;

  assign fire = in_valid && in_ready;

  always_comb begin
    ca             = aslex_pkg::classify(slash_held_r ? aslex_pkg::CH_SLASH : in_ch,
                                         st_r, COUNT_CAP);
    cb             = aslex_pkg::classify(in_ch, ca.st, COUNT_CAP);
    hold           = 1'b0;
    st_nxt         = st_r;
    slash_held_nxt = 1'b0;
    entry.two      = 1'b0;
    entry.line_end = in_line_end;
    entry.r0       = '{ch: in_ch, kind: ca.kind, count: ca.st.token_count};
    entry.r1       = '{ch: in_ch, kind: cb.kind, count: cb.st.token_count};
    if (slash_held_r) begin
      entry.two = 1'b1;
      if (in_ch == aslex_pkg::CH_SLASH) begin
        st_nxt             = st_r;
        st_nxt.commenting  = 1'b1;
        st_nxt.inside_word = 1'b0;
        entry.r0 = '{ch: aslex_pkg::CH_SLASH, kind: aslex_pkg::KIND_DROP,
                     count: st_r.token_count};
        entry.r1 = '{ch: aslex_pkg::CH_SLASH, kind: aslex_pkg::KIND_DROP,
                     count: st_r.token_count};
      end else begin
        st_nxt      = cb.st;
        entry.r0.ch = aslex_pkg::CH_SLASH;
      end
    end else if (in_ch == aslex_pkg::CH_SLASH && !st_r.commenting && !in_line_end) begin
      hold           = 1'b1;
      slash_held_nxt = 1'b1;
    end else begin
      st_nxt = ca.st;
    end
    if (in_line_end) begin
      st_nxt         = '0;
      slash_held_nxt = 1'b0;
    end
  end

  assign push = fire && !hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      slash_held_r <= 1'b0;
    end else if (fire) begin
      st_r         <= st_nxt;
      slash_held_r <= slash_held_nxt;
    end
  end

endmodule

// ----- rtl/core/aslex_fifo.sv -----
// Short queue of entries between the lexer front end and back end.
// Depth and entry type come from aslex_pkg.
module aslex_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  aslex_pkg::entry_t    wr_entry,
  input  logic                 pop,
  output aslex_pkg::entry_t    head,
  output aslex_pkg::q_status_t status
);

  localparam int                  Depth = aslex_pkg::FifoDepth;
  localparam int                  PtrW  = aslex_pkg::PtrW;
  localparam int                  CntW  = aslex_pkg::CntW;
  localparam logic [PtrW-1:0]     LastPtr = PtrW'(Depth - 1);

  aslex_pkg::entry_t mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == CntW'(Depth));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/aslex_back.sv -----
// Back end of the lexer: presents the results of the queue head one per
// transfer and releases the entry after its last result. Depends on aslex_pkg.
module aslex_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  aslex_pkg::entry_t           head,
  input  aslex_pkg::q_status_t        status,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_ch,
  output logic [1:0]                  out_kind,
  output logic [aslex_pkg::CountW-1:0] out_tokens_in_line,
  output logic                        out_line_done,
  output logic                        out_last
);

  logic            second_r, second_nxt;
  logic            xfer;
  aslex_pkg::res_t res;

  assign out_valid          = !status.empty;
  assign res                = second_r ? head.r1 : head.r0;
  assign out_ch             = res.ch;
  assign out_kind           = res.kind;
  assign out_tokens_in_line = res.count;
  assign out_last           = !head.two || second_r;
  assign out_line_done      = head.line_end && out_last;
  assign xfer               = out_valid && out_ready;
  assign pop                = xfer && out_last;

  always_comb begin
    second_nxt = second_r;
    if (xfer) begin
      second_nxt = !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

endmodule
